// ===== hw/rtl/piecewise_linear_density_eval_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the density evaluator checker.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_DENSITY_EVAL_MACROS_SVH
`define PIECEWISE_LINEAR_DENSITY_EVAL_MACROS_SVH

// Implication checked every clock, disabled in reset.
`define PLD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pld_pkg.sv =====
// ---------------------------------------------------------------------------
// pld_pkg
// Shared types and constants of the piecewise linear density evaluator.
// ---------------------------------------------------------------------------
package pld_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned IndexW = 4;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic       start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } pld_div_req_t;
endpackage

// ===== hw/rtl/pld_ram.sv =====
// ---------------------------------------------------------------------------
// pld_ram
// Generic single-port write, single-port read RAM with registered read.
// ---------------------------------------------------------------------------
module pld_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/pld_div.sv =====
// ---------------------------------------------------------------------------
// pld_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module pld_div
  import pld_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  pld_div_req_t req,
  output logic         done,
  output logic [63:0]  quot
);
  logic [63:0] q;
  logic [31:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [31:0] dvs;

  // remainder stays below the divisor, so the shifted value fits 33 bits
  assign trial = {rem, q[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        q    <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[30:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
endmodule

// ===== hw/rtl/piecewise_linear_density_eval.sv =====
// Order: a write result is valid in the cycle after its transfer. A query reads
//   both span ends, stops outside the span, else runs 1 to MAX_POINTS-1 segment
//   compares; a found positive-width segment then uses the 64/32 divider.
// Throughput: one item at a time; the next transfer is taken the cycle after the
//   result transfer. Reset: synchronous, active high; clears control and
//   points_in_use to 2. Table contents are not cleared.
// ---------------------------------------------------------------------------
// piecewise_linear_density_eval
// Table lookup in two RAMs, serial segment search and interpolation.
// ---------------------------------------------------------------------------
module piecewise_linear_density_eval
  import pld_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CountW-1:0]       cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic [IndexW-1:0]       point_index,
  input  logic signed [DataW-1:0] point_position,
  input  logic [DataW-1:0]        point_density,
  input  logic signed [DataW-1:0] query_x,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DataW-1:0]        density,
  output logic                    outside_support,
  output logic                    saturated
);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RLO   = 9'b000000010,
    S_RHI   = 9'b000000100,
    S_SRCH  = 9'b000001000,
    S_SCMP  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_WAIT  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [CountW-1:0] points_in_use;
  logic [AW-1:0] nlast;
  logic signed [DataW-1:0] qx, xlo, x1;
  logic [DataW-1:0] v1;
  logic [AW-1:0] seg;
  logic [AW-1:0] raddr;
  logic [DataW-1:0] bp_rd, dn_rd;
  logic wr_en;
  logic signed [33:0] span_c, dx_c, dv_c;
  logic [31:0] span_r, adx, adv;
  logic neg;
  logic [63:0] prod;
  pld_div_req_t dreq;
  logic ddone;
  logic [63:0] dq;
  logic [32:0] sum;

  always_comb begin
    if (points_in_use < CountW'(2)) nlast = AW'(1);
    else if (32'(points_in_use) > MAX_POINTS) nlast = AW'(MAX_POINTS - 1);
    else nlast = AW'(points_in_use - CountW'(1));
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign wr_en = in_valid && in_ready && (func == FuncWrite)
                 && (32'(point_index) < MAX_POINTS);

  pld_ram #(.Width(DataW), .Depth(MAX_POINTS)) u_bp (
    .clk, .we(wr_en), .waddr(AW'(point_index)), .wdata(point_position),
    .raddr, .rdata(bp_rd));
  pld_ram #(.Width(DataW), .Depth(MAX_POINTS)) u_dn (
    .clk, .we(wr_en), .waddr(AW'(point_index)), .wdata(point_density),
    .raddr, .rdata(dn_rd));

  always_comb begin
    raddr = '0;
    case (state)
      S_IDLE:  raddr = '0;
      S_RLO:   raddr = nlast;
      S_SRCH:  raddr = seg;
      default: raddr = seg;
    endcase
  end

  // segment terms against the entry just read
  always_comb begin
    span_c = 34'($signed(bp_rd)) - 34'(x1);
    dx_c = 34'(qx) - 34'(x1);
    dv_c = $signed({2'b0, dn_rd}) - $signed({2'b0, v1});
  end

  pld_div u_div (.clk, .rst, .req(dreq), .done(ddone), .quot(dq));

  assign dreq.start = (state == S_DIV);
  assign dreq.dividend = prod;
  assign dreq.divisor = span_r;

  assign sum = {1'b0, v1} + {1'b0, dq[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      points_in_use <= CountW'(2);
    end else begin
      if (cfg_we) points_in_use <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            density <= '0;
            outside_support <= 1'b0;
            saturated <= 1'b0;
            qx <= query_x;
            if (func == FuncWrite) begin
              out_valid <= 1'b1;
            end else begin
              state <= S_RLO;
            end
          end
        end
        S_RLO: begin
          xlo <= bp_rd;
          x1 <= bp_rd;
          v1 <= dn_rd;
          state <= S_RHI;
        end
        S_RHI: begin
          if (qx < xlo || qx > $signed(bp_rd)) begin
            outside_support <= 1'b1;
            state <= S_OUT;
          end else begin
            seg <= AW'(1);
            state <= S_SRCH;
          end
        end
        S_SRCH: state <= S_SCMP;
        S_SCMP: begin
          if (qx <= $signed(bp_rd)) begin
            if (span_c[33] || span_c == '0) begin
              density <= dn_rd;
              state <= S_OUT;
            end else begin
              span_r <= span_c[31:0];
              adx <= dx_c[33] ? 32'(-dx_c) : dx_c[31:0];
              adv <= dv_c[33] ? 32'(-dv_c) : dv_c[31:0];
              neg <= dx_c[33] != dv_c[33];
              state <= S_MUL;
            end
          end else if (seg == nlast) begin
            state <= S_OUT;
          end else begin
            x1 <= bp_rd;
            v1 <= dn_rd;
            seg <= seg + AW'(1);
            state <= S_SRCH;
          end
        end
        S_MUL: begin
          prod <= 64'(adx) * 64'(adv);
          state <= S_DIV;
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (ddone) begin
            if (dq == 64'd0) begin
              density <= v1;
            end else if (neg) begin
              if (dq > 64'(v1)) begin
                density <= '0;
                saturated <= 1'b1;
              end else begin
                density <= v1 - dq[31:0];
              end
            end else if (dq[63:32] != 32'd0 || sum[32]) begin
              density <= '1;
              saturated <= 1'b1;
            end else begin
              density <= sum[31:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/pld_checker.sv =====
// ---------------------------------------------------------------------------
// pld_checker
// Port-level checks of the density evaluator.
// ---------------------------------------------------------------------------
`include "piecewise_linear_density_eval_macros.svh"
module pld_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] density,
  input logic        outside_support,
  input logic        saturated
);
  `PLD_ASSERT_IMP(a_out_excl, clk, rst, out_valid && outside_support, !saturated && density == 32'd0, "outside result not zero")
  `PLD_ASSERT_IMP(a_sat_val, clk, rst, out_valid && saturated, density == 32'd0 || density == 32'hFFFFFFFF, "saturated value not at bound")
  `PLD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(density), "result dropped")
  `PLD_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "second transfer taken while busy")
endmodule

bind piecewise_linear_density_eval pld_checker u_pld_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .density, .outside_support, .saturated);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Density evaluator testbench
// Loads breakpoint tables, sweeps the point count through its extremes and
// checks every query and table write against an in-bench interpolator or a
// fixed expected result, with bursty input traffic and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_top;
  import pld_pkg::*;

  localparam int NPts = 16;
  localparam int IdleWait = 120;
  localparam int WdogLimit = 5000;

  typedef struct packed {
    logic [DataW-1:0] density;
    logic             outside;
    logic             sat;
  } dens_res_t;

  typedef struct {
    logic             f;
    logic [3:0]       idx;
    logic [31:0]      pos;
    logic [31:0]      dens;
    logic [31:0]      qx;
    bit               fixed;
    dens_res_t        res;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CountW-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic func = FuncWrite;
  logic [IndexW-1:0] point_index = '0;
  logic signed [DataW-1:0] point_position = '0;
  logic [DataW-1:0] point_density = '0;
  logic signed [DataW-1:0] query_x = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [DataW-1:0] density;
  logic outside_support;
  logic saturated;
  logic fixed_chk = 0;
  dens_res_t fixed_res = '0;

  logic [31:0] bp_tab [NPts];
  logic [31:0] dv_tab [NPts];
  logic [CountW-1:0] count_reg;
  dens_res_t density_q[$];
  int errors = 0;
  int n_writes = 0, n_queries = 0, n_outside = 0, n_results = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  longint tpos [NPts];

  piecewise_linear_density_eval #(.MAX_POINTS(NPts)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .point_index(point_index), .point_position(point_position),
    .point_density(point_density), .query_x(query_x),
    .out_valid(out_valid), .out_ready(out_ready), .density(density),
    .outside_support(outside_support), .saturated(saturated)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic dens_res_t interpolate(logic f, logic [3:0] idx, logic [31:0] pos,
                                            logic [31:0] dens, logic [31:0] qx);
    dens_res_t r;
    int n;
    longint x, x1, x2, span, dx, dv;
    longint unsigned adx, adv, q;
    bit neg, found;
    r = '0;
    found = 0;
    if (f == FuncWrite) begin
      bp_tab[idx] = pos;
      dv_tab[idx] = dens;
      return r;
    end
    n = (count_reg < 2) ? 2 : ((count_reg > NPts) ? NPts : count_reg);
    x = longint'($signed(qx));
    if (x < longint'($signed(bp_tab[0])) || x > longint'($signed(bp_tab[n-1]))) begin
      r.outside = 1;
      return r;
    end
    for (int i = 0; i + 1 < n; i++) begin
      x1 = longint'($signed(bp_tab[i]));
      x2 = longint'($signed(bp_tab[i+1]));
      if (!found && x <= x2) begin
        found = 1;
        span = x2 - x1;
        if (span <= 0) begin
          r.density = dv_tab[i+1];
        end else begin
          dx = x - x1;
          dv = longint'(dv_tab[i+1]) - longint'(dv_tab[i]);
          adx = (dx < 0) ? -dx : dx;
          adv = (dv < 0) ? -dv : dv;
          neg = (dx < 0) != (dv < 0);
          q = (adx * adv) / longint'(span);
          if (q == 0) begin
            r.density = dv_tab[i];
          end else if (neg) begin
            if (q > dv_tab[i]) begin
              r.sat = 1;
            end else begin
              r.density = 32'(dv_tab[i] - q);
            end
          end else begin
            if (q > 64'hFFFF_FFFF - dv_tab[i]) begin
              r.density = '1;
              r.sat = 1;
            end else begin
              r.density = 32'(dv_tab[i] + q);
            end
          end
        end
      end
    end
    return r;
  endfunction

  // transfer monitors and scoreboard
  always @(posedge clk) begin
    dens_res_t e;
    if (rst) begin
      count_reg = CountW'(2);
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        e = interpolate(func, point_index, point_position, point_density, query_x);
        if (fixed_chk) e = fixed_res;
        density_q.push_back(e);
        if (func == FuncWrite) n_writes++;
        else n_queries++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (density_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = density_q.pop_front();
          if (outside_support) n_outside++;
          if (density !== e.density) begin
            $error("density: expected %h, got %h", e.density, density);
            errors++;
          end
          if (outside_support !== e.outside) begin
            $error("outside_support: expected %b, got %b", e.outside, outside_support);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated: expected %b, got %b", e.sat, saturated);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("timeout: no transfer for %0d cycles", WdogLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // sink stall pattern
  always @(negedge clk) begin
    int mode;
    int cnt;
    if (cnt <= 0) begin
      mode = $urandom_range(0, 3);
      cnt = $urandom_range(50, 400);
    end
    cnt--;
    case (mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((cnt % 7) < 3);
    endcase
  end

  task automatic send(logic f, logic [3:0] idx, logic [31:0] pos, logic [31:0] dens,
                      logic [31:0] qx, bit fx = 0, dens_res_t fr = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    func <= f;
    point_index <= idx;
    point_position <= pos;
    point_density <= dens;
    query_x <= qx;
    fixed_chk <= fx;
    fixed_res <= fr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_config(logic [CountW-1:0] v);
    in_valid <= 0;
    burst_left = 0;
    while (density_q.size() != 0) @(negedge clk);
    repeat (IdleWait) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic load_table(int kind, int n);
    longint step;
    if (kind == 0) begin
      tpos[0] = -64'sd2147483648 + $urandom_range(0, 32'h000F_FFFF);
      step = 64'sd1 << 28;
    end else begin
      tpos[0] = longint'($signed($urandom)) / 4;
      step = 64'sd131072;
    end
    for (int i = 1; i < NPts; i++) tpos[i] = tpos[i-1] + 1 + ($urandom % step);
    if (kind == 2) begin
      tpos[$urandom_range(1, n - 1)] = tpos[$urandom_range(0, n - 2)];
      if ($urandom_range(0, 1)) tpos[n/2] = tpos[0] - 5;
    end
    for (int i = 0; i < NPts; i++) send(FuncWrite, 4'(i), 32'(tpos[i]), $urandom, $urandom);
  endtask

  initial begin
    dir_row_t dir [] = '{
      '{FuncWrite, 4'd0, 32'h8000_0000, 32'h0, 32'h0, 1, '0},
      '{FuncWrite, 4'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h8000_0000, 1, '0},
      '{FuncQuery, 4'd15, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 0, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h0, 0, '0},
      '{FuncWrite, 4'd0, 32'h0, 32'd100, 32'h0, 1, '0},
      '{FuncWrite, 4'd1, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 1, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1, '{32'h0, 1'b1, 1'b0}},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h0001_0001, 1, '{32'h0, 1'b1, 1'b0}},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h0001_0000, 1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h0000_8000, 0, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h0, 1, '{32'd100, 1'b0, 1'b0}},
      '{FuncWrite, 4'd1, 32'h0, 32'd5, 32'h0, 1, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h0, 1, '{32'd5, 1'b0, 1'b0}},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h1, 1, '{32'h0, 1'b1, 1'b0}},
      '{FuncWrite, 4'd1, 32'hFFFF_0000, 32'd7, 32'h0, 1, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 1'b1, 1'b0}},
      '{FuncWrite, 4'd1, 32'h0000_0003, 32'd0, 32'h0, 1, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h1, 0, '0},
      '{FuncQuery, 4'd0, 32'h0, 32'h0, 32'h2, 0, '0}
    };
    logic [CountW-1:0] counts [] = '{5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd5, 5'd9,
                                     5'd2, 5'd3, 5'd12, 5'd16};
    int n, kind, nq;
    longint lo, hi;
    logic [31:0] qx;

    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (dir[i]) send(dir[i].f, dir[i].idx, dir[i].pos, dir[i].dens, dir[i].qx,
                          dir[i].fixed, dir[i].res);
    fixed_chk <= 0;
    foreach (counts[p]) begin
      drain_and_config(counts[p]);
      n = (counts[p] < 2) ? 2 : ((counts[p] > NPts) ? NPts : counts[p]);
      kind = (p % 4 == 3) ? 2 : $urandom_range(0, 1);
      load_table(kind, n);
      lo = (tpos[0] < tpos[n-1]) ? tpos[0] : tpos[n-1];
      hi = (tpos[0] < tpos[n-1]) ? tpos[n-1] : tpos[0];
      nq = $urandom_range(75, 95);
      for (int k = 0; k < nq; k++) begin
        case ($urandom_range(0, 19))
          0, 1: qx = 32'(tpos[$urandom_range(0, n - 1)]);
          2, 3: qx = $urandom;
          4: qx = 32'(lo - 1);
          5: qx = 32'(hi + 1);
          default: qx = 32'(lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1)));
        endcase
        if (n < NPts && $urandom_range(0, 19) == 0)
          send(FuncWrite, 4'($urandom_range(n, NPts - 1)), $urandom, $urandom, $urandom);
        else
          send(FuncQuery, 4'($urandom), $urandom, $urandom, qx);
      end
    end
    in_valid <= 0;
    while (density_q.size() != 0) @(negedge clk);
    repeat (IdleWait) @(negedge clk);
    $display("Covered %0d table writes and %0d queries (%0d outside span), %0d results,",
             n_writes, n_queries, n_outside, n_results);
    $display("across point counts from below 2 to above 16.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pld_pkg.sv
hw/rtl/pld_ram.sv
hw/rtl/pld_div.sv
hw/rtl/piecewise_linear_density_eval.sv
hw/rtl/pld_checker.sv
dv/tb_top.sv
